@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define CHK_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked on the edge after the antecedent holds.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

@@ src/crfm_pkg.sv @@
// Shared types and constants of the framed message ring.
package crfm_pkg;

    localparam logic [7:0] CR_CODE = 8'd13;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_CLOSE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_STREAM
    } back_state_t;

endpackage

@@ src/crfm_front.sv @@
// Front end: accepts words, classifies them and queues commands for the back end.
module crfm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              req_type,
    input  logic [7:0]        rx_byte,
    output logic              cmd_valid,
    output crfm_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    localparam int PTR_W = $clog2(crfm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(crfm_pkg::QUEUE_DEPTH + 1);

    crfm_pkg::cmd_t queue_reg [crfm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    crfm_pkg::cmd_t   item_cmd;
    logic             push;
    logic             pop;

    always_comb
    begin
        item_cmd.data = rx_byte;
        if (req_type)
        begin
            item_cmd.kind = crfm_pkg::CMD_READ;
        end
        else if (rx_byte == crfm_pkg::CR_CODE)
        begin
            item_cmd.kind = crfm_pkg::CMD_CLOSE;
        end
        else
        begin
            item_cmd.kind = crfm_pkg::CMD_CHAR;
        end
    end

    assign item_stall = (fill_reg == CNT_W'(crfm_pkg::QUEUE_DEPTH));
    assign cmd_valid  = (fill_reg != '0);
    assign cmd        = queue_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_cmd;
        end
    end

endmodule

@@ src/crfm_back.sv @@
// Back end: slot store, ring pointers, message count and result streaming.
module crfm_back #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  crfm_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [7:0]     msg_byte,
    output logic           last_of_message,
    output logic           no_message,
    output logic           empty_message,
    output logic           still_available
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = crfm_pkg::COUNT_W;

    crfm_pkg::back_state_t state_reg;
    crfm_pkg::back_state_t state_next;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic [LEN_W-1:0]  len_reg [SLOT_COUNT];
    logic [SLOT_W-1:0] ws_reg;
    logic [SLOT_W-1:0] ws_next;
    logic [SLOT_W-1:0] rs_reg;
    logic [SLOT_W-1:0] rs_next;
    logic [LEN_W-1:0]  wlen_reg;
    logic [LEN_W-1:0]  wlen_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              flag_reg;
    logic              flag_next;
    logic [SLOT_W-1:0] sslot_reg;
    logic [SLOT_W-1:0] sslot_next;
    logic [LEN_W-1:0]  sidx_reg;
    logic [LEN_W-1:0]  sidx_next;
    logic [LEN_W-1:0]  slen_reg;
    logic [LEN_W-1:0]  slen_next;
    logic              savail_reg;
    logic              savail_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              res_last_reg;
    logic              res_last_next;
    logic              res_none_reg;
    logic              res_none_next;
    logic              res_empty_reg;
    logic              res_empty_next;
    logic              res_avail_reg;
    logic              res_avail_next;
    logic              res_mem_reg;
    logic              res_mem_next;

    logic              load_ok;
    logic [LEN_W-1:0]  rlen;
    logic              new_flag;
    logic              mem_we;
    logic              mem_re;
    logic              len_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                    input logic [LEN_W-1:0] i);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES)) + ADDR_W'(i);
    endfunction

    assign load_ok  = !res_valid_reg || !result_stall;
    assign rlen     = (rs_reg == ws_reg) ? wlen_reg : len_reg[rs_reg];
    assign new_flag = (count_reg > CW'(1));
    assign waddr    = slot_addr(ws_reg, wlen_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crfm_pkg::BACK_IDLE:
            begin
                if (cmd_valid && (cmd.kind == crfm_pkg::CMD_READ) && load_ok && flag_reg
                    && (rlen > LEN_W'(1)))
                begin
                    state_next = crfm_pkg::BACK_STREAM;
                end
            end
            crfm_pkg::BACK_STREAM:
            begin
                if (load_ok && (sidx_reg == slen_reg - LEN_W'(1)))
                begin
                    state_next = crfm_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = crfm_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        len_we         = 1'b0;
        raddr          = slot_addr(sslot_reg, sidx_reg);
        ws_next        = ws_reg;
        rs_next        = rs_reg;
        wlen_next      = wlen_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        sslot_next     = sslot_reg;
        sidx_next      = sidx_reg;
        slen_next      = slen_reg;
        savail_next    = savail_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_last_next  = res_last_reg;
        res_none_next  = res_none_reg;
        res_empty_next = res_empty_reg;
        res_avail_next = res_avail_reg;
        res_mem_next   = res_mem_reg;
        case (state_reg)
            crfm_pkg::BACK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        crfm_pkg::CMD_CHAR:
                        begin
                            cmd_pop = 1'b1;
                            if (wlen_reg < LEN_W'(SLOT_BYTES))
                            begin
                                mem_we    = 1'b1;
                                wlen_next = wlen_reg + LEN_W'(1);
                            end
                        end
                        crfm_pkg::CMD_CLOSE:
                        begin
                            cmd_pop   = 1'b1;
                            len_we    = 1'b1;
                            ws_next   = slot_inc(ws_reg);
                            wlen_next = '0;
                            flag_next = 1'b1;
                            if (count_reg != crfm_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        crfm_pkg::CMD_READ:
                        begin
                            if (load_ok)
                            begin
                                cmd_pop        = 1'b1;
                                res_valid_next = 1'b1;
                                res_mem_next   = 1'b0;
                                res_none_next  = 1'b0;
                                res_empty_next = 1'b0;
                                res_last_next  = 1'b1;
                                res_avail_next = new_flag;
                                if (!flag_reg)
                                begin
                                    res_none_next  = 1'b1;
                                    res_avail_next = 1'b0;
                                end
                                else
                                begin
                                    flag_next  = new_flag;
                                    count_next = new_flag ? count_reg - CW'(1) : '0;
                                    rs_next    = slot_inc(rs_reg);
                                    if (rlen == '0)
                                    begin
                                        res_empty_next = 1'b1;
                                    end
                                    else
                                    begin
                                        mem_re        = 1'b1;
                                        raddr         = slot_addr(rs_reg, '0);
                                        res_mem_next  = 1'b1;
                                        res_last_next = (rlen == LEN_W'(1));
                                        sslot_next    = rs_reg;
                                        sidx_next     = LEN_W'(1);
                                        slen_next     = rlen;
                                        savail_next   = new_flag;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            crfm_pkg::BACK_STREAM:
            begin
                if (load_ok)
                begin
                    mem_re         = 1'b1;
                    res_valid_next = 1'b1;
                    res_mem_next   = 1'b1;
                    res_none_next  = 1'b0;
                    res_empty_next = 1'b0;
                    res_avail_next = savail_reg;
                    res_last_next  = (sidx_reg == slen_reg - LEN_W'(1));
                    sidx_next      = sidx_reg + LEN_W'(1);
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crfm_pkg::BACK_IDLE;
            ws_reg        <= '0;
            rs_reg        <= '0;
            wlen_reg      <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            wlen_reg      <= wlen_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            res_valid_reg <= res_valid_next;
            if (len_we)
            begin
                len_reg[ws_reg] <= wlen_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sslot_reg     <= sslot_next;
        sidx_reg      <= sidx_next;
        slen_reg      <= slen_next;
        savail_reg    <= savail_next;
        res_last_reg  <= res_last_next;
        res_none_reg  <= res_none_next;
        res_empty_reg <= res_empty_next;
        res_avail_reg <= res_avail_next;
        res_mem_reg   <= res_mem_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign result_valid    = res_valid_reg;
    assign msg_byte        = res_mem_reg ? rdata_reg : 8'd0;
    assign last_of_message = res_last_reg;
    assign no_message      = res_none_reg;
    assign empty_message   = res_empty_reg;
    assign still_available = res_avail_reg;

endmodule

@@ src/cr_framed_message_ring.sv @@
// Top level of the carriage-return framed message ring.
//
//   Channel   Handshake                     Fields
//   item      item_valid / item_stall       req_type, rx_byte
//   result    result_valid / result_stall   msg_byte, last_of_message, no_message,
//                                           empty_message, still_available
//
// Received bytes pass through the back end at one per cycle while no read is streaming.
// A read streams the characters of its slot through the single read port of the
// character store, and the back end takes no new word while it does so; words
// reach the back end through a two-word command queue. Reset clears the slot
// lengths, pointers, count and flag at once; the character store is not cleared.
// A stalled result holds a read in the back end, and the queue then fills and
// stalls the item side.
module cr_framed_message_ring #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] msg_byte,
    output logic       last_of_message,
    output logic       no_message,
    output logic       empty_message,
    output logic       still_available
);

    logic           cmd_valid;
    logic           cmd_pop;
    crfm_pkg::cmd_t cmd;

    crfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .req_type   (req_type),
        .rx_byte    (rx_byte),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    crfm_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .msg_byte        (msg_byte),
        .last_of_message (last_of_message),
        .no_message      (no_message),
        .empty_message   (empty_message),
        .still_available (still_available)
    );

endmodule

@@ src/crfm_checker.sv @@
// Port-level checks on the framed message ring and their binding.
`include "assert_macros.svh"

module crfm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] msg_byte,
    input logic       last_of_message,
    input logic       no_message,
    input logic       empty_message,
    input logic       still_available
);

    `CHK_CLK(a_none_shape, result_valid && no_message |-> last_of_message && !empty_message && !still_available && (msg_byte == 8'd0), "Malformed no-message word.")

    `CHK_CLK(a_empty_shape, result_valid && empty_message |-> last_of_message && !no_message && (msg_byte == 8'd0), "Malformed empty-message word.")

    `CHK_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(msg_byte) && $stable(last_of_message) && $stable(still_available), "Stalled result word changed.")

endmodule

bind cr_framed_message_ring crfm_checker u_crfm_checker (.*);
